### rtl/bspb_pkg.sv
// bspb_pkg: shared types and constants for the bit stream pack/unpack buffer
// used by the interfaces, the controller, the datapath and the top level
package bspb_pkg;

    localparam int OP_W    = 4;
    localparam int VAL_W   = 33;
    localparam int CNT_W   = 6;
    localparam int POS_W   = 13;
    localparam int DEPTH_W = 8;

    // operation codes
    localparam logic [OP_W-1:0] OP_WR_UNS = 4'd0;
    localparam logic [OP_W-1:0] OP_WR_SGN = 4'd1;
    localparam logic [OP_W-1:0] OP_RD_UNS = 4'd2;
    localparam logic [OP_W-1:0] OP_RD_SGN = 4'd3;
    localparam logic [OP_W-1:0] OP_SEEK   = 4'd4;
    localparam logic [OP_W-1:0] OP_CLEAR  = 4'd5;
    localparam logic [OP_W-1:0] OP_START  = 4'd6;
    localparam logic [OP_W-1:0] OP_END    = 4'd7;
    localparam logic [OP_W-1:0] OP_EXCISE = 4'd8;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 8'd255;
    localparam logic [CNT_W-1:0]   FIELD_MAX = 6'd32;
    localparam logic [CNT_W-1:0]   BYTE_BITS = 6'd8;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_WIPE,
        ACT_LATCH,
        ACT_EXEC,
        ACT_XCHK,
        ACT_CHECK,
        ACT_WRITE,
        ACT_READ,
        ACT_XCOPY,
        ACT_FINISH
    } t_act;

    typedef struct packed {
        t_act act;
        logic is_bit;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            alt;
        logic            n_bad;
        logic            rd;
        logic            go;
        logic            wr_last;
        logic            cnt_done;
        logic            wipe_done;
        logic            x_ok;
        logic            out_free;
    } t_stat;

endpackage

### rtl/bspb_in_if.sv
// bspb_in_if: operation channel of the bit stream buffer
// depends on bspb_pkg for field widths
interface bspb_in_if;
    logic                                valid;
    logic                                ready;
    logic [bspb_pkg::OP_W-1:0]           op;
    logic signed [bspb_pkg::VAL_W-1:0]   write_value;
    logic [bspb_pkg::CNT_W-1:0]          bit_count;
    logic [bspb_pkg::POS_W-1:0]          position;
    logic [bspb_pkg::POS_W-1:0]          remove_count;

    modport source (output valid, op, write_value, bit_count, position, remove_count,
                    input ready);
    modport sink (input valid, op, write_value, bit_count, position, remove_count,
                  output ready);
endinterface

### rtl/bspb_out_if.sv
// bspb_out_if: result channel of the bit stream buffer
// depends on bspb_pkg for field widths
interface bspb_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [bspb_pkg::VAL_W-1:0]   read_value;
    logic                                success;
    logic                                overflow_flag;
    logic [bspb_pkg::POS_W-1:0]          cursor_bit;
    logic [bspb_pkg::POS_W-1:0]          bits_left;
    logic [bspb_pkg::DEPTH_W-1:0]        sign_depth;

    modport source (output valid, read_value, success, overflow_flag, cursor_bit,
                    bits_left, sign_depth, input ready);
    modport sink (input valid, read_value, success, overflow_flag, cursor_bit,
                  bits_left, sign_depth, output ready);
endinterface

### rtl/bspb_cfg_if.sv
// bspb_cfg_if: configuration write channel for the buffer size register
// depends on bspb_pkg for the register width
interface bspb_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [bspb_pkg::POS_W-1:0]  buffer_size_bits;

    modport source (output valid, buffer_size_bits, input ready);
    modport sink (input valid, buffer_size_bits, output ready);
endinterface

### rtl/bit_stream_pack_unpack_buffer.sv
// bit_stream_pack_unpack_buffer: top level of the lsb-first bit stream buffer
// depends on bspb_pkg, the bspb interfaces, bspb_ctrl, bspb_dp and bspb_ram
//
// usage
// - i_in carries one operation per beat: field write/read (unsigned or signed),
//   seek, clear, start/end of an alternate-sign section, excise
// - o_out returns exactly one result beat per operation, in order
// - i_cfg writes the buffer size; it is always ready and reloads the used length
// - the bit store is a 1-bit wide ram with registered read, one bit per cycle
// sequencing
// - a field write or read moves its bits through the store one at a time,
//   and a signed field adds a second check and a separate sign bit step
// - seek, clear and section ops make no access to the bit store
// - excise copies the tail one bit per cycle
// - the bit-serial store port sets the rate; at most one operation is in flight
// reset
// - after reset a wipe pass writes zeros over all BUF_BITS bits, one per cycle;
//   i_in stays not ready until the wipe pass ends, config writes are taken as ever
// stalls
// - a held result sits in the output register; the next beat is accepted and
//   worked on, and its result waits until the output register is free
module bit_stream_pack_unpack_buffer #(
    parameter int BUF_BITS = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bspb_in_if.sink          i_in,
    bspb_out_if.source       o_out,
    bspb_cfg_if.sink         i_cfg
);
    bspb_pkg::t_cmd  cmd;
    bspb_pkg::t_stat stat;
    logic            in_ready;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    // sequencer: one command per cycle to the datapath
    bspb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath: cursor, length, flags, bit store and result register
    bspb_dp #(.BUF_BITS(BUF_BITS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_op            (i_in.op),
        .i_write_value   (i_in.write_value),
        .i_bit_count     (i_in.bit_count),
        .i_position      (i_in.position),
        .i_remove_count  (i_in.remove_count),
        .i_cfg_valid     (i_cfg.valid),
        .i_cfg_data      (i_cfg.buffer_size_bits),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_read_value    (o_out.read_value),
        .o_success       (o_out.success),
        .o_overflow_flag (o_out.overflow_flag),
        .o_cursor_bit    (o_out.cursor_bit),
        .o_bits_left     (o_out.bits_left),
        .o_sign_depth    (o_out.sign_depth)
    );

`ifndef SYNTHESIS
    a_accept_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> (cmd.act == bspb_pkg::ACT_LATCH))
        else $error("accepted beat not latched");
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.act == bspb_pkg::ACT_FINISH) |=> o_out.valid)
        else $error("finished result not presented");
    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.act == bspb_pkg::ACT_WIPE) |-> !i_in.ready)
        else $error("ready during wipe");
`endif
endmodule

### rtl/bspb_ram.sv
// bspb_ram: generic simple dual port ram, one write and one registered read
// no dependencies
module bspb_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/bspb_ctrl.sv
// bspb_ctrl: sequencer of the bit stream buffer, issues one command per cycle
// depends on bspb_pkg for the command and status structs
module bspb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  bspb_pkg::t_stat i_stat,
    output bspb_pkg::t_cmd  o_cmd
);
    typedef enum logic [7:0] {
        S_WIPE   = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_DECODE = 8'b0000_0100,
        S_CHECK  = 8'b0000_1000,
        S_WRITE  = 8'b0001_0000,
        S_READ   = 8'b0010_0000,
        S_XCOPY  = 8'b0100_0000,
        S_FIN    = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_two, n_two;
    logic   r_is_bit, n_is_bit;
    logic   op_sgn;

    assign op_sgn = (i_stat.op == bspb_pkg::OP_WR_SGN) || (i_stat.op == bspb_pkg::OP_RD_SGN);

    always_comb begin
        n_state    = r_state;
        n_two      = r_two;
        n_is_bit   = r_is_bit;
        o_cmd.act  = bspb_pkg::ACT_NONE;
        o_cmd.is_bit = r_is_bit;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_WIPE: begin
                o_cmd.act = bspb_pkg::ACT_WIPE;
                if (i_stat.wipe_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.act = bspb_pkg::ACT_LATCH;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (i_stat.op == bspb_pkg::OP_WR_UNS ||
                             i_stat.op == bspb_pkg::OP_RD_UNS) begin
                    n_two    = 1'b0;
                    n_is_bit = 1'b0;
                    n_state  = S_CHECK;
                end else if (op_sgn && !i_stat.n_bad) begin
                    n_two    = 1'b1;
                    n_is_bit = i_stat.alt;
                    n_state  = S_CHECK;
                end else if (i_stat.op == bspb_pkg::OP_EXCISE) begin
                    o_cmd.act = bspb_pkg::ACT_XCHK;
                    n_state   = i_stat.x_ok ? S_XCOPY : S_FIN;
                end else begin
                    o_cmd.act = bspb_pkg::ACT_EXEC;
                    n_state   = S_FIN;
                end
            end
            S_CHECK: begin
                o_cmd.act = bspb_pkg::ACT_CHECK;
                if (i_stat.go) begin
                    n_state = i_stat.rd ? S_READ : S_WRITE;
                end else if (r_two) begin
                    n_two    = 1'b0;
                    n_is_bit = !r_is_bit;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_WRITE, S_READ: begin
                o_cmd.act = (r_state == S_WRITE) ? bspb_pkg::ACT_WRITE : bspb_pkg::ACT_READ;
                if ((r_state == S_WRITE) ? i_stat.wr_last : i_stat.cnt_done) begin
                    if (r_two) begin
                        n_two    = 1'b0;
                        n_is_bit = !r_is_bit;
                        n_state  = S_CHECK;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_XCOPY: begin
                o_cmd.act = bspb_pkg::ACT_XCOPY;
                if (i_stat.cnt_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.act = bspb_pkg::ACT_FINISH;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_WIPE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_WIPE;
            r_two    <= 1'b0;
            r_is_bit <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_two    <= n_two;
            r_is_bit <= n_is_bit;
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == S_IDLE))
        else $error("ready outside idle");
    a_latch_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.act == bspb_pkg::ACT_LATCH) |=> (r_state == S_DECODE))
        else $error("latched beat not decoded");
    a_two_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_two && r_state != S_CHECK && r_state != S_WRITE && r_state != S_READ &&
         r_state != S_DECODE) |-> (r_state == S_IDLE || r_state == S_WIPE ||
         r_state == S_FIN || r_state == S_XCOPY))
        else $error("second step pending in wrong state");
`endif
endmodule

### rtl/bspb_dp.sv
// bspb_dp: datapath of the bit stream buffer, cursor/length/flags and bit store
// depends on bspb_pkg and bspb_ram
module bspb_dp #(
    parameter int BUF_BITS = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bspb_pkg::t_cmd                      i_cmd,
    output bspb_pkg::t_stat                     o_stat,
    input  logic [bspb_pkg::OP_W-1:0]           i_op,
    input  logic signed [bspb_pkg::VAL_W-1:0]   i_write_value,
    input  logic [bspb_pkg::CNT_W-1:0]          i_bit_count,
    input  logic [bspb_pkg::POS_W-1:0]          i_position,
    input  logic [bspb_pkg::POS_W-1:0]          i_remove_count,
    input  logic                                i_cfg_valid,
    input  logic [bspb_pkg::POS_W-1:0]          i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [bspb_pkg::VAL_W-1:0]   o_read_value,
    output logic                                o_success,
    output logic                                o_overflow_flag,
    output logic [bspb_pkg::POS_W-1:0]          o_cursor_bit,
    output logic [bspb_pkg::POS_W-1:0]          o_bits_left,
    output logic [bspb_pkg::DEPTH_W-1:0]        o_sign_depth
);
    localparam int AW = $clog2(BUF_BITS);
    localparam int CW = ($clog2(BUF_BITS + 1) > bspb_pkg::POS_W) ?
                        $clog2(BUF_BITS + 1) : bspb_pkg::POS_W;
    localparam int USED_RST = (BUF_BITS < 4096) ? BUF_BITS : 4096;

    // latched item
    logic [bspb_pkg::OP_W-1:0]  r_op;
    logic [31:0]                r_wv;
    logic [bspb_pkg::CNT_W-1:0] r_n;
    logic [CW-1:0]              r_pos, r_rem;
    // architectural state
    logic [CW-1:0]               r_cursor, r_used;
    logic                        r_ovf;
    logic [bspb_pkg::DEPTH_W-1:0] r_depth;
    // working registers
    logic [31:0]   r_shift, r_fval;
    logic          r_sbit, r_ok;
    logic [CW-1:0] r_cnt, r_lim, r_xsrc;
    logic [AW-1:0] r_wipe;
    // result register
    logic                              r_ovalid;
    logic signed [bspb_pkg::VAL_W-1:0] r_rv;
    logic                              r_osucc, r_oovf;
    logic [bspb_pkg::POS_W-1:0]        r_ocur, r_oleft;
    logic [bspb_pkg::DEPTH_W-1:0]      r_odepth;

    logic [CW-1:0]              avail, cfg_used, x_end;
    logic [bspb_pkg::CNT_W-1:0] fn;
    logic                       rd, sgn, alt, neg;
    logic                       chk_short, chk_bad, chk_big, go;
    logic [31:0]                fval_in, mag;
    logic [CW:0]                align_t;
    logic [4:0]                 cap_idx;
    logic signed [bspb_pkg::VAL_W-1:0] rv_next;
    logic                       we, rdata;
    logic [AW-1:0]              waddr, raddr;
    logic                       wdata;

    assign avail = (r_cursor > r_used) ? '0 : r_used - r_cursor;
    assign rd    = (r_op == bspb_pkg::OP_RD_UNS) || (r_op == bspb_pkg::OP_RD_SGN);
    assign sgn   = (r_op == bspb_pkg::OP_WR_SGN) || (r_op == bspb_pkg::OP_RD_SGN);
    assign alt   = (r_depth != '0);
    assign neg   = r_wv[31];
    assign mag   = neg ? (32'd0 - r_wv) : r_wv;
    assign fn    = i_cmd.is_bit ? 6'd1 : (sgn ? r_n - 6'd1 : r_n);
    assign x_end = r_pos + r_rem;

    assign cfg_used = (CW'(i_cfg_data) > CW'(BUF_BITS)) ? CW'(BUF_BITS) : CW'(i_cfg_data);

    // field access screening
    assign chk_short = rd && !i_cmd.is_bit && (fn == bspb_pkg::BYTE_BITS) && (avail < CW'(8));
    assign chk_bad   = !i_cmd.is_bit && ((fn == '0) || (fn > bspb_pkg::FIELD_MAX));
    assign chk_big   = CW'(fn) > avail;
    assign go        = !chk_short && !chk_bad && !chk_big && !r_ovf;

    always_comb begin
        priority if (i_cmd.is_bit) begin
            fval_in = {31'd0, neg};
        end else if (!sgn) begin
            fval_in = r_wv;
        end else if (alt) begin
            fval_in = mag;
        end else begin
            fval_in = r_wv + 32'h8000_0000;
        end
    end

    assign align_t = {1'b0, r_cursor | CW'(7)} + (CW+1)'(1);
    assign cap_idx = 5'(r_cnt - CW'(1));

    always_comb begin
        rv_next = '0;
        if (r_op == bspb_pkg::OP_RD_UNS) begin
            rv_next = {1'b0, r_fval};
        end else if (r_op == bspb_pkg::OP_RD_SGN) begin
            if (!r_sbit) begin
                rv_next = {1'b0, r_fval};
            end else if (alt) begin
                rv_next = -{1'b0, r_fval};
            end else begin
                rv_next = {1'b0, r_fval} - (33'd1 << (r_n - 6'd1));
            end
        end
    end

    assign o_stat.op        = r_op;
    assign o_stat.alt       = alt;
    assign o_stat.n_bad     = (r_n == '0) || (r_n > bspb_pkg::FIELD_MAX);
    assign o_stat.rd        = rd;
    assign o_stat.go        = go;
    assign o_stat.wr_last   = (r_cnt == r_lim - CW'(1));
    assign o_stat.cnt_done  = (r_cnt == r_lim);
    assign o_stat.wipe_done = (r_wipe == AW'(BUF_BITS - 1));
    assign o_stat.x_ok      = !((r_pos > r_used) || (r_rem > r_used - r_pos));
    assign o_stat.out_free  = !r_ovalid || i_out_ready;

    // store port muxing
    always_comb begin
        we    = 1'b0;
        waddr = r_cursor[AW-1:0];
        wdata = r_shift[0];
        raddr = r_cursor[AW-1:0];
        unique case (i_cmd.act)
            bspb_pkg::ACT_WIPE: begin
                we    = 1'b1;
                waddr = r_wipe;
                wdata = 1'b0;
            end
            bspb_pkg::ACT_WRITE: begin
                we = 1'b1;
            end
            bspb_pkg::ACT_XCOPY: begin
                we    = (r_cnt != '0);
                waddr = AW'(r_pos + r_cnt - CW'(1));
                wdata = rdata;
                raddr = AW'(r_xsrc + r_cnt);
            end
            default: begin
            end
        endcase
    end

    bspb_ram #(.WIDTH(1), .DEPTH(BUF_BITS)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_used   <= CW'(USED_RST);
            r_ovf    <= 1'b0;
            r_depth  <= '0;
            r_wipe   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_used <= cfg_used;
            end
            unique case (i_cmd.act)
                bspb_pkg::ACT_WIPE: begin
                    r_wipe <= r_wipe + AW'(1);
                end
                bspb_pkg::ACT_LATCH: begin
                    r_op    <= i_op;
                    r_wv    <= i_write_value[31:0];
                    r_n     <= i_bit_count;
                    r_pos   <= CW'(i_position);
                    r_rem   <= CW'(i_remove_count);
                    r_fval  <= '0;
                    r_sbit  <= 1'b0;
                    r_ok    <= 1'b1;
                end
                bspb_pkg::ACT_EXEC: begin
                    unique case (r_op)
                        bspb_pkg::OP_WR_SGN, bspb_pkg::OP_RD_SGN: begin
                            r_ovf    <= 1'b1;
                            r_cursor <= r_used;
                        end
                        bspb_pkg::OP_SEEK: begin
                            if (r_pos > r_used) begin
                                r_ok <= 1'b0;
                            end else begin
                                r_cursor <= r_pos;
                            end
                        end
                        bspb_pkg::OP_CLEAR: begin
                            r_cursor <= '0;
                            r_ovf    <= 1'b0;
                            r_depth  <= '0;
                        end
                        bspb_pkg::OP_START: begin
                            if (r_depth != bspb_pkg::DEPTH_MAX) begin
                                r_depth <= r_depth + 8'd1;
                            end
                        end
                        bspb_pkg::OP_END: begin
                            if (r_depth == '0) begin
                                r_ok <= 1'b0;
                            end else begin
                                r_depth <= r_depth - 8'd1;
                                if ((r_cursor[2:0] != 3'd0) && (align_t <= {1'b0, r_used})) begin
                                    r_cursor <= align_t[CW-1:0];
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                bspb_pkg::ACT_XCHK: begin
                    if (!o_stat.x_ok) begin
                        r_ovf <= 1'b1;
                        r_ok  <= 1'b0;
                    end else begin
                        r_xsrc   <= x_end;
                        r_lim    <= r_used - x_end;
                        r_cnt    <= '0;
                        r_used   <= r_used - r_rem;
                        r_cursor <= r_pos;
                    end
                end
                bspb_pkg::ACT_CHECK: begin
                    priority if (chk_short) begin
                    end else if (chk_bad) begin
                        r_ovf    <= 1'b1;
                        r_cursor <= r_used;
                    end else if (chk_big || r_ovf) begin
                        r_ovf <= 1'b1;
                        if (!i_cmd.is_bit) begin
                            r_cursor <= r_used;
                        end
                    end else begin
                        r_cnt   <= '0;
                        r_lim   <= CW'(fn);
                        r_shift <= fval_in;
                    end
                end
                bspb_pkg::ACT_WRITE: begin
                    r_shift  <= r_shift >> 1;
                    r_cursor <= r_cursor + CW'(1);
                    r_cnt    <= r_cnt + CW'(1);
                end
                bspb_pkg::ACT_READ: begin
                    if (r_cnt != r_lim) begin
                        r_cursor <= r_cursor + CW'(1);
                    end
                    if (r_cnt != '0) begin
                        if (i_cmd.is_bit) begin
                            r_sbit <= rdata;
                        end else begin
                            r_fval[cap_idx] <= rdata;
                        end
                    end
                    r_cnt <= r_cnt + CW'(1);
                end
                bspb_pkg::ACT_XCOPY: begin
                    r_cnt <= r_cnt + CW'(1);
                end
                bspb_pkg::ACT_FINISH: begin
                    r_ovalid <= 1'b1;
                    r_rv     <= rv_next;
                    r_osucc  <= r_ok;
                    r_oovf   <= r_ovf;
                    r_ocur   <= r_cursor[bspb_pkg::POS_W-1:0];
                    r_oleft  <= avail[bspb_pkg::POS_W-1:0];
                    r_odepth <= r_depth;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_read_value    = r_rv;
    assign o_success       = r_osucc;
    assign o_overflow_flag = r_oovf;
    assign o_cursor_bit    = r_ocur;
    assign o_bits_left     = r_oleft;
    assign o_sign_depth    = r_odepth;

`ifndef SYNTHESIS
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.act == bspb_pkg::ACT_WRITE) |-> (r_cursor < r_used))
        else $error("store write beyond used length");
    a_ovf_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovf) |-> ($past(i_cmd.act) == bspb_pkg::ACT_CHECK ||
                          $past(i_cmd.act) == bspb_pkg::ACT_EXEC ||
                          $past(i_cmd.act) == bspb_pkg::ACT_XCHK))
        else $error("overflow set outside a check");
    a_depth_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_depth) |-> ($past(i_cmd.act) == bspb_pkg::ACT_EXEC))
        else $error("depth changed outside exec");
`endif
endmodule
